// ===== src/ctc_pkg.sv =====
package ctc_pkg;

    localparam int RING_DEPTH_DEF = 32;
    localparam int PCT_SCALE      = 100;
    localparam int MS_SCALE       = 1000;

    localparam int STAMP_W    = 48;
    localparam int VALUE_W    = 32;
    localparam int TAG_W      = 16;
    localparam int KIND_W     = 2;
    localparam int PCT_W      = 10;
    localparam int MS_W       = 22;
    localparam int AVG_W      = 37;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 37;
    localparam int SUM_W      = 64;
    localparam int CNT_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_PCT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_MS     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POST_MS    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_US     = 8'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_FWD    = 2'd0,
        KIND_REPLAY = 2'd1,
        KIND_AVG    = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_DECIDE,
        ST_FWD,
        ST_RPL_RD,
        ST_RPL,
        ST_RING_WR,
        ST_PR_RD,
        ST_PR,
        ST_AVG,
        ST_DIV,
        ST_AVG_OUT
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [VALUE_W-1:0] value;
        logic [STAMP_W-1:0]        stamp;
    } ring_entry_t;

endpackage

// ===== src/ctc_if.sv =====
interface ctc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  is_watched;
    logic                                  has_trigger;
    logic signed [ctc_pkg::VALUE_W-1:0]    sample_value;
    logic [ctc_pkg::STAMP_W-1:0]           stamp_us;
    logic [ctc_pkg::TAG_W-1:0]             reading_tag;

    modport source (output valid, is_watched, has_trigger, sample_value, stamp_us,
                    reading_tag, input ready);
    modport sink (input valid, is_watched, has_trigger, sample_value, stamp_us,
                  reading_tag, output ready);
endinterface

interface ctc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [ctc_pkg::KIND_W-1:0]            kind;
    logic [ctc_pkg::TAG_W-1:0]             out_tag;
    logic signed [ctc_pkg::VALUE_W-1:0]    out_value;
    logic [ctc_pkg::STAMP_W-1:0]           out_stamp_us;
    logic                                  last;

    modport source (output valid, kind, out_tag, out_value, out_stamp_us, last,
                    input ready);
    modport sink (input valid, kind, out_tag, out_value, out_stamp_us, last,
                  output ready);
endinterface

interface ctc_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [ctc_pkg::CFG_IDX_W-1:0]         index;
    logic [ctc_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/change_triggered_capture_unit.sv =====
// Change-triggered capture of timestamped readings. Readings that are not watched are
// passed through; a watched reading whose value moves far enough from the reference fires
// a trigger, which replays the buffered pre-trigger words oldest first and then forwards
// readings until the post-trigger window closes. An input word is accepted in the idle
// state and passes through the difference, multiply and decide states before it is
// forwarded; a replay reads every buffered word through the single read port of the ring
// memory. A watched word that is not forwarded goes through the averaging step, and when
// it is stored in the ring, older entries are aged out one at a time; an emitted average
// is computed by the bit-serial divider. Every result waits in the output register until
// the sink takes it. The block takes no new word until the current one is finished.
module change_triggered_capture_unit #(
    parameter int RING_DEPTH = ctc_pkg::RING_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ctc_in_if.sink    sample_ch,
    ctc_out_if.source result_ch,
    ctc_cfg_if.sink   cfg_ch
);

    import ctc_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);

    state_t state_reg, state_next;

    logic [PCT_W-1:0] pct_reg, pct_next;
    logic [MS_W-1:0]  pre_reg, pre_next;
    logic [MS_W-1:0]  post_reg, post_next;
    logic [AVG_W-1:0] avgint_reg, avgint_next;

    logic                      watched_reg, watched_next;
    logic                      has_reg, has_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [STAMP_W-1:0]        stamp_reg, stamp_next;
    logic [TAG_W-1:0]          tag_reg, tag_next;

    logic                      triggered_reg, triggered_next;
    logic                      ref_valid_reg, ref_valid_next;
    logic signed [VALUE_W-1:0] ref_reg, ref_next;
    logic [STAMP_W-1:0]        stop_reg, stop_next;
    logic [STAMP_W-1:0]        last_sent_reg, last_sent_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [IW-1:0]             head_reg, head_next;
    logic [FW-1:0]             fill_reg, fill_next;

    logic [VALUE_W:0]   diff_reg, diff_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [39:0]        pa_reg, pa_next;
    logic [41:0]        pb_reg, pb_next;
    logic [31:0]        post_us_reg, post_us_next;
    logic [31:0]        lim_reg, lim_next;

    logic [SUM_W-1:0] dq_reg, dq_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [5:0]       dcnt_reg, dcnt_next;
    logic             neg_reg, neg_next;

    logic                      ov_reg, ov_next;
    kind_t                     okind_reg, okind_next;
    logic [TAG_W-1:0]          otag_reg, otag_next;
    logic signed [VALUE_W-1:0] oval_reg, oval_next;
    logic [STAMP_W-1:0]        ostamp_reg, ostamp_next;
    logic                      olast_reg, olast_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    ring_entry_t   ram_wdata;
    ring_entry_t   ram_rdata;

    logic                      slot_free;
    logic                      fire;
    logic signed [VALUE_W:0]   dsig;
    logic [STAMP_W:0]          stop_sum;
    logic [STAMP_W-1:0]        stop_sat;
    logic [IW:0]               wsum;
    logic signed [SUM_W-1:0]   sum_n;
    logic [CNT_W-1:0]          cnt_n;
    logic [CNT_W:0]            shifted;
    logic [CNT_W:0]            trial;
    logic [IW-1:0]             head_inc;
    logic [VALUE_W-1:0]        q32;

    ctc_ram #(
        .WIDTH($bits(ring_entry_t)),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign sample_ch.ready      = (state_reg == ST_IDLE);
    assign cfg_ch.ready         = 1'b1;
    assign result_ch.valid      = ov_reg;
    assign result_ch.kind       = okind_reg;
    assign result_ch.out_tag    = otag_reg;
    assign result_ch.out_value  = oval_reg;
    assign result_ch.out_stamp_us = ostamp_reg;
    assign result_ch.last       = olast_reg;

    assign slot_free = !ov_reg || result_ch.ready;
    assign head_inc  = (head_reg == IW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pct_reg       <= '0;
            pre_reg       <= '0;
            post_reg      <= '0;
            avgint_reg    <= '0;
            triggered_reg <= 1'b0;
            ref_valid_reg <= 1'b0;
            ref_reg       <= '0;
            stop_reg      <= '0;
            last_sent_reg <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pct_reg       <= pct_next;
            pre_reg       <= pre_next;
            post_reg      <= post_next;
            avgint_reg    <= avgint_next;
            triggered_reg <= triggered_next;
            ref_valid_reg <= ref_valid_next;
            ref_reg       <= ref_next;
            stop_reg      <= stop_next;
            last_sent_reg <= last_sent_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        watched_reg <= watched_next;
        has_reg     <= has_next;
        val_reg     <= val_next;
        stamp_reg   <= stamp_next;
        tag_reg     <= tag_next;
        diff_reg    <= diff_next;
        mag_reg     <= mag_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        post_us_reg <= post_us_next;
        lim_reg     <= lim_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        neg_reg     <= neg_next;
        okind_reg   <= okind_next;
        otag_reg    <= otag_next;
        oval_reg    <= oval_next;
        ostamp_reg  <= ostamp_next;
        olast_reg   <= olast_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pct_next       = pct_reg;
        pre_next       = pre_reg;
        post_next      = post_reg;
        avgint_next    = avgint_reg;
        watched_next   = watched_reg;
        has_next       = has_reg;
        val_next       = val_reg;
        stamp_next     = stamp_reg;
        tag_next       = tag_reg;
        triggered_next = triggered_reg;
        ref_valid_next = ref_valid_reg;
        ref_next       = ref_reg;
        stop_next      = stop_reg;
        last_sent_next = last_sent_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        diff_next      = diff_reg;
        mag_next       = mag_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        post_us_next   = post_us_reg;
        lim_next       = lim_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        neg_next       = neg_reg;
        ov_next        = ov_reg;
        okind_next     = okind_reg;
        otag_next      = otag_reg;
        oval_next      = oval_reg;
        ostamp_next    = ostamp_reg;
        olast_next     = olast_reg;

        ram_we    = 1'b0;
        ram_waddr = head_reg;
        ram_wdata = '{tag: tag_reg, value: val_reg, stamp: stamp_reg};

        dsig     = {ref_reg[VALUE_W-1], ref_reg} - {val_reg[VALUE_W-1], val_reg};
        fire     = has_reg && ref_valid_reg &&
                   ((pct_reg == '0) ? (diff_reg != '0) : ({2'b00, pa_reg} >= pb_reg));
        stop_sum = {1'b0, stamp_reg} + (STAMP_W + 1)'(post_us_reg);
        stop_sat = stop_sum[STAMP_W] ? '1 : stop_sum[STAMP_W-1:0];
        wsum     = (IW + 1)'(head_reg) + (IW + 1)'(fill_reg);
        if (wsum >= (IW + 1)'(RING_DEPTH))
        begin
            wsum = wsum - (IW + 1)'(RING_DEPTH);
        end
        sum_n    = sum_reg;
        cnt_n    = cnt_reg;
        shifted  = {rem_reg, dq_reg[SUM_W-1]};
        trial    = shifted - {1'b0, cnt_reg};
        q32      = neg_reg ? VALUE_W'(-dq_reg[VALUE_W-1:0]) : dq_reg[VALUE_W-1:0];

        if (ov_reg && result_ch.ready)
        begin
            ov_next = 1'b0;
        end

        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_CHANGE_PCT: pct_next    = cfg_ch.data[PCT_W-1:0];
                REG_PRE_MS:     pre_next    = cfg_ch.data[MS_W-1:0];
                REG_POST_MS:    post_next   = cfg_ch.data[MS_W-1:0];
                REG_AVG_US:     avgint_next = cfg_ch.data[AVG_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    watched_next = sample_ch.is_watched;
                    has_next     = sample_ch.has_trigger;
                    val_next     = sample_ch.sample_value;
                    stamp_next   = sample_ch.stamp_us;
                    tag_next     = sample_ch.reading_tag;
                    state_next   = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                diff_next  = dsig[VALUE_W] ? (VALUE_W + 1)'(-dsig) : (VALUE_W + 1)'(dsig);
                mag_next   = ref_reg[VALUE_W-1] ? VALUE_W'(-ref_reg) : VALUE_W'(ref_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                pa_next      = 40'(diff_reg) * 40'(PCT_SCALE);
                pb_next      = 42'(mag_reg) * 42'(pct_reg);
                post_us_next = 32'(post_reg) * 32'(MS_SCALE);
                lim_next     = 32'(pre_reg) * 32'(MS_SCALE);
                state_next   = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!watched_reg)
                begin
                    state_next = ST_FWD;
                end
                else
                begin
                    if (has_reg && !ref_valid_reg)
                    begin
                        ref_next       = val_reg;
                        ref_valid_next = 1'b1;
                    end
                    if (fire)
                    begin
                        ref_next  = val_reg;
                        stop_next = stop_sat;
                    end
                    if (triggered_reg && (fire || stamp_reg <= stop_reg))
                    begin
                        state_next = ST_FWD;
                    end
                    else if (fire)
                    begin
                        triggered_next = 1'b1;
                        sum_next       = '0;
                        cnt_next       = '0;
                        state_next     = (fill_reg != '0) ? ST_RPL_RD : ST_FWD;
                    end
                    else
                    begin
                        triggered_next = 1'b0;
                        state_next     = (pre_reg != '0) ? ST_RING_WR : ST_AVG;
                    end
                end
            end
            ST_FWD:
            begin
                if (slot_free)
                begin
                    ov_next     = 1'b1;
                    okind_next  = KIND_FWD;
                    otag_next   = tag_reg;
                    oval_next   = val_reg;
                    ostamp_next = stamp_reg;
                    olast_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_RPL_RD:
            begin
                state_next = ST_RPL;
            end
            ST_RPL:
            begin
                if (slot_free)
                begin
                    ov_next     = 1'b1;
                    okind_next  = KIND_REPLAY;
                    otag_next   = ram_rdata.tag;
                    oval_next   = ram_rdata.value;
                    ostamp_next = ram_rdata.stamp;
                    olast_next  = 1'b0;
                    head_next   = head_inc;
                    fill_next   = fill_reg - 1'b1;
                    state_next  = (fill_reg == FW'(1)) ? ST_FWD : ST_RPL_RD;
                end
            end
            ST_RING_WR:
            begin
                ram_we = 1'b1;
                if (fill_reg == FW'(RING_DEPTH))
                begin
                    ram_waddr = head_reg;
                    head_next = head_inc;
                end
                else
                begin
                    ram_waddr = wsum[IW-1:0];
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_PR_RD;
            end
            ST_PR_RD:
            begin
                state_next = ST_PR;
            end
            ST_PR:
            begin
                if (ram_rdata.stamp <= stamp_reg &&
                    (stamp_reg - ram_rdata.stamp) > STAMP_W'(lim_reg))
                begin
                    head_next  = head_inc;
                    fill_next  = fill_reg - 1'b1;
                    state_next = ST_PR_RD;
                end
                else
                begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                if (avgint_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (cnt_reg != '1)
                    begin
                        if (has_reg)
                        begin
                            sum_n = sum_reg + SUM_W'(val_reg);
                        end
                        cnt_n = cnt_reg + 1'b1;
                    end
                    sum_next = sum_n;
                    cnt_next = cnt_n;
                    if ({1'b0, stamp_reg} > ({1'b0, last_sent_reg} + (STAMP_W + 1)'(avgint_reg)))
                    begin
                        neg_next   = sum_n[SUM_W-1];
                        dq_next    = sum_n[SUM_W-1] ? SUM_W'(-sum_n) : SUM_W'(sum_n);
                        rem_next   = '0;
                        dcnt_next  = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                if (!trial[CNT_W])
                begin
                    rem_next = trial[CNT_W-1:0];
                    dq_next  = {dq_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[CNT_W-1:0];
                    dq_next  = {dq_reg[SUM_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == '1)
                begin
                    state_next = ST_AVG_OUT;
                end
            end
            ST_AVG_OUT:
            begin
                if (slot_free)
                begin
                    ov_next        = 1'b1;
                    okind_next     = KIND_AVG;
                    otag_next      = tag_reg;
                    oval_next      = q32;
                    ostamp_next    = stamp_reg;
                    olast_next     = 1'b1;
                    sum_next       = '0;
                    cnt_next       = '0;
                    last_sent_next = stamp_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/ctc_ram.sv =====
module ctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
